@@ design/lpkt_pkg.sv @@
`default_nettype none

package lpkt_pkg;

	localparam int TABLE_SLOTS_DEF = 4 * 1024;
	localparam int ID_BITS_DEF     = 32;

	// operation codes
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_TAKE   = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	// result codes
	localparam logic [2:0] RC_INSERTED = 3'd0;
	localparam logic [2:0] RC_PRESENT  = 3'd1;
	localparam logic [2:0] RC_FULL     = 3'd2;
	localparam logic [2:0] RC_HIT      = 3'd3;
	localparam logic [2:0] RC_MISS     = 3'd4;
	localparam logic [2:0] RC_REMOVED  = 3'd5;
	localparam logic [2:0] RC_NONE     = 3'd6;

	// slot status codes
	localparam logic [1:0] SLOT_EMPTY   = 2'd0;
	localparam logic [1:0] SLOT_FILLED  = 2'd1;
	localparam logic [1:0] SLOT_DELETED = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] outer_class_id;
		logic [31:0] outer_selector_id;
		logic        has_inner;
		logic [31:0] inner_class_id;
		logic [31:0] inner_selector_id;
	} lpkt_req_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [11:0] slot_index;
		logic [31:0] found_class_id;
		logic [31:0] found_selector_id;
		logic [11:0] entry_count;
		logic        scan_exhausted;
	} lpkt_rsp_t;

	typedef struct packed {
		logic rd_en;
		logic st_we;
		logic key_we;
	} lpkt_mem_ctl_t;

endpackage

`default_nettype wire

@@ design/lpkt_store.sv @@
`default_nettype none

module lpkt_store import lpkt_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF,
	localparam int IDX_W      = $clog2(TABLE_SLOTS),
	localparam int ENTRY_W    = 4 * ID_BITS + 1
) (
	input  wire logic                 clk,
	input  wire lpkt_mem_ctl_t        ctl,
	input  wire logic [IDX_W-1:0]     rd_addr,
	input  wire logic [IDX_W-1:0]     wr_addr,
	input  wire logic [1:0]           st_wdata,
	input  wire logic [ENTRY_W-1:0]   key_wdata,
	output logic      [1:0]           st_rdata,
	output logic      [ENTRY_W-1:0]   key_rdata
);

	logic [1:0]         status_mem [TABLE_SLOTS];
	logic [ENTRY_W-1:0] key_mem    [TABLE_SLOTS];
	logic [1:0]         st_rdata_q;
	logic [ENTRY_W-1:0] key_rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.st_we) begin
			status_mem[wr_addr] <= st_wdata;
		end
		if (ctl.rd_en) begin
			st_rdata_q <= status_mem[rd_addr];
		end
	end

	// entry: {inner present, inner key, outer key}
	always_ff @(posedge clk) begin
		if (ctl.key_we) begin
			key_mem[wr_addr] <= key_wdata;
		end
		if (ctl.rd_en) begin
			key_rdata_q <= key_mem[rd_addr];
		end
	end

	assign st_rdata  = st_rdata_q;
	assign key_rdata = key_rdata_q;

endmodule

`default_nettype wire

@@ design/lpkt_seq.sv @@
`default_nettype none

module lpkt_seq import lpkt_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF,
	localparam int IDX_W      = $clog2(TABLE_SLOTS),
	localparam int KEY_W      = 2 * ID_BITS,
	localparam int ENTRY_W    = 2 * KEY_W + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	input  wire lpkt_req_t            req,
	output logic                      req_stall,
	input  wire logic                 out_free,
	output logic                      rsp_load,
	output lpkt_rsp_t                 rsp,
	output lpkt_mem_ctl_t             mem_ctl,
	output logic      [IDX_W-1:0]     rd_addr,
	output logic      [IDX_W-1:0]     wr_addr,
	output logic      [1:0]           st_wdata,
	output logic      [ENTRY_W-1:0]   key_wdata,
	input  wire logic [1:0]           st_rdata,
	input  wire logic [ENTRY_W-1:0]   key_rdata
);

	localparam logic [IDX_W:0] HALF = (IDX_W + 1)'(TABLE_SLOTS / 2);

	typedef enum logic [4:0] {
		S_CLR   = 5'b00001,
		S_IDLE  = 5'b00010,
		S_PROBE = 5'b00100,
		S_WRITE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [2:0]         op_q;
	logic               hi_q;
	logic [KEY_W-1:0]   okey_q;
	logic [KEY_W-1:0]   ikey_q;
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   n_q;
	logic [IDX_W-1:0]   free_q;
	logic               free_seen_q;
	logic               resp_q;
	logic [IDX_W-1:0]   count_q;
	logic [2:0]         res_code_q;
	logic [IDX_W-1:0]   res_slot_q;
	logic [ID_BITS-1:0] res_fc_q;
	logic [ID_BITS-1:0] res_fs_q;
	logic               res_eot_q;

	logic [ID_BITS-1:0] in_oc, in_os, in_ic, in_is;
	logic [31:0]        hash32;
	logic [IDX_W-1:0]   start_addr;
	logic               is_keyop;
	logic               req_fire;

	logic [KEY_W-1:0]   r_outer, r_inner;
	logic               r_pres;
	logic               st_filled, st_empty;
	logic               match, take_hit, last, full, cont;
	logic [IDX_W-1:0]   free_now;
	logic [31:0]        slot_ext, cnt_ext, fc_ext, fs_ext;

	// request decode and home slot
	always_comb begin
		in_oc      = req.outer_class_id[ID_BITS-1:0];
		in_os      = req.outer_selector_id[ID_BITS-1:0];
		in_ic      = req.has_inner ? req.inner_class_id[ID_BITS-1:0] : '0;
		in_is      = req.has_inner ? req.inner_selector_id[ID_BITS-1:0] : '0;
		hash32     = 32'(in_oc ^ in_os ^ in_ic ^ in_is);
		is_keyop   = (req.operation == OP_INSERT) || (req.operation == OP_LOOKUP) ||
			(req.operation == OP_REMOVE);
		start_addr = is_keyop ? hash32[IDX_W-1:0] : '0;
		req_fire   = req_valid && (state_q == S_IDLE);
	end

	// compare unit on the slot just read
	always_comb begin
		r_outer   = key_rdata[KEY_W-1:0];
		r_inner   = key_rdata[2*KEY_W-1:KEY_W];
		r_pres    = key_rdata[2*KEY_W];
		st_filled = (st_rdata == SLOT_FILLED);
		st_empty  = (st_rdata == SLOT_EMPTY);
		match     = st_filled && (r_outer == okey_q) && (r_pres == hi_q) &&
			(!hi_q || (r_inner == ikey_q));
		take_hit  = st_filled && !r_pres;
		last      = &n_q;
		full      = {1'b0, count_q} >= HALF;
		free_now  = free_seen_q ? free_q : cur_q;
		cont      = (state_q == S_PROBE) && !last &&
			((op_q == OP_TAKE) ? !take_hit : (!match && !st_empty));
	end

	always_comb begin
		mem_ctl.rd_en  = req_fire || cont;
		mem_ctl.st_we  = (state_q == S_CLR) || (state_q == S_WRITE);
		mem_ctl.key_we = (state_q == S_WRITE) && (op_q == OP_INSERT);
		rd_addr        = (state_q == S_IDLE) ? start_addr : cur_q + 1'b1;
		wr_addr        = (state_q == S_CLR) ? cur_q : res_slot_q;
		st_wdata       = (state_q == S_CLR) ? SLOT_EMPTY :
			((op_q == OP_INSERT) ? SLOT_FILLED : SLOT_DELETED);
		key_wdata      = {hi_q, ikey_q, okey_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cur_q       <= '0;
			n_q         <= '0;
			free_seen_q <= 1'b0;
			resp_q      <= 1'b0;
			count_q     <= '0;
			op_q        <= OP_CLEAR;
		end else begin
			unique case (state_q)
				S_CLR: begin
					cur_q <= cur_q + 1'b1;
					if (&cur_q) begin
						count_q <= '0;
						state_q <= resp_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						op_q        <= req.operation;
						cur_q       <= start_addr;
						n_q         <= '0;
						free_seen_q <= 1'b0;
						resp_q      <= (req.operation == OP_CLEAR);
						unique case (req.operation)
							OP_INSERT, OP_TAKE: state_q <= S_PROBE;
							OP_LOOKUP, OP_REMOVE: begin
								state_q <= (count_q == '0) ? S_DONE : S_PROBE;
							end
							OP_CLEAR: state_q <= S_CLR;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PROBE: begin
					if (cont) begin
						cur_q <= cur_q + 1'b1;
						n_q   <= n_q + 1'b1;
					end
					unique case (op_q)
						OP_INSERT: begin
							if (!free_seen_q && !st_filled) begin
								free_seen_q <= 1'b1;
								free_q      <= cur_q;
							end
							if (match) begin
								state_q <= S_DONE;
							end else if (st_empty || last) begin
								state_q <= full ? S_DONE : S_WRITE;
							end
						end
						OP_LOOKUP, OP_REMOVE: begin
							if (match) begin
								state_q <= (op_q == OP_REMOVE) ? S_WRITE : S_DONE;
							end else if (st_empty || last) begin
								state_q <= S_DONE;
							end
						end
						OP_TAKE: begin
							if (take_hit) begin
								state_q <= S_WRITE;
							end else if (last) begin
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_WRITE: begin
					count_q <= (op_q == OP_INSERT) ? count_q + 1'b1 : count_q - 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request key and result fields
	always_ff @(posedge clk) begin
		if (req_fire) begin
			hi_q       <= req.has_inner;
			okey_q     <= {in_oc, in_os};
			ikey_q     <= {in_ic, in_is};
			res_slot_q <= '0;
			res_fc_q   <= '0;
			res_fs_q   <= '0;
			res_eot_q  <= 1'b0;
			res_code_q <= (req.operation == OP_LOOKUP || req.operation == OP_REMOVE) ?
				RC_MISS : RC_NONE;
		end else if (state_q == S_PROBE) begin
			unique case (op_q)
				OP_INSERT: begin
					if (match) begin
						res_code_q <= RC_PRESENT;
						res_slot_q <= cur_q;
					end else if ((st_empty || last) && full) begin
						res_code_q <= RC_FULL;
					end else if (st_empty || last) begin
						res_code_q <= RC_INSERTED;
						res_slot_q <= free_now;
					end
				end
				OP_LOOKUP, OP_REMOVE: begin
					if (match) begin
						res_code_q <= (op_q == OP_REMOVE) ? RC_REMOVED : RC_HIT;
						res_slot_q <= cur_q;
					end
				end
				OP_TAKE: begin
					if (take_hit) begin
						res_code_q <= RC_REMOVED;
						res_slot_q <= cur_q;
						res_fc_q   <= r_outer[KEY_W-1:ID_BITS];
						res_fs_q   <= r_outer[ID_BITS-1:0];
					end else if (last) begin
						res_eot_q  <= 1'b1;
					end
				end
				default: res_code_q <= RC_NONE;
			endcase
		end
	end

	always_comb begin
		slot_ext              = 32'(res_slot_q);
		cnt_ext               = 32'(count_q);
		fc_ext                = 32'(res_fc_q);
		fs_ext                = 32'(res_fs_q);
		rsp.result_code       = res_code_q;
		rsp.slot_index        = slot_ext[11:0];
		rsp.found_class_id    = fc_ext;
		rsp.found_selector_id = fs_ext;
		rsp.entry_count       = cnt_ext[11:0];
		rsp.scan_exhausted    = res_eot_q;
		rsp_load              = (state_q == S_DONE) && out_free;
		req_stall             = (state_q != S_IDLE);
	end

endmodule

`default_nettype wire

@@ design/linear_probe_key_table.sv @@
// probing: insert, lookup and remove probe slot by slot from the home slot, with a write
//   when the table changes; take-next scans from slot 0, and clear sweeps every slot
// throughput: one item at a time, bound by the single read port of the slot memory
// reset: async active-low; afterwards a sweep marks every slot
//   empty, with req_stall high until it ends
`default_nettype none

module linear_probe_key_table import lpkt_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire lpkt_req_t req_data,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output lpkt_rsp_t      rsp_data
);

	localparam int IDX_W   = $clog2(TABLE_SLOTS);
	localparam int ENTRY_W = 4 * ID_BITS + 1;

	lpkt_mem_ctl_t      mem_ctl;
	logic [IDX_W-1:0]   rd_addr, wr_addr;
	logic [1:0]         st_wdata, st_rdata;
	logic [ENTRY_W-1:0] key_wdata, key_rdata;
	logic               out_free, rsp_load;
	lpkt_rsp_t          rsp_next;
	logic               rsp_valid_q;
	lpkt_rsp_t          rsp_q;

	lpkt_seq #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.ID_BITS     (ID_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req_data),
		.req_stall (req_stall),
		.out_free  (out_free),
		.rsp_load  (rsp_load),
		.rsp       (rsp_next),
		.mem_ctl   (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.st_wdata  (st_wdata),
		.key_wdata (key_wdata),
		.st_rdata  (st_rdata),
		.key_rdata (key_rdata)
	);

	lpkt_store #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.ID_BITS     (ID_BITS)
	) u_store (
		.clk       (clk),
		.ctl       (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.st_wdata  (st_wdata),
		.key_wdata (key_wdata),
		.st_rdata  (st_rdata),
		.key_rdata (key_rdata)
	);

	// output register frees the sequencer while a beat waits
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

@@ tb/tb_linear_probe_key_table.sv @@
`default_nettype none

module tb_linear_probe_key_table;
	import lpkt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS          = TABLE_SLOTS_DEF;
	localparam int unsigned SLOT_MASK      = SLOTS - 1;
	localparam int unsigned WATCHDOG_LIMIT = 40000;
	localparam int unsigned RANDOM_ITEMS   = 700;
	localparam int unsigned POOL_DEPTH     = 48;
	localparam int unsigned MAX_REPORTS    = 50;

	typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	lpkt_req_t req_data  = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	lpkt_rsp_t rsp_data;

	linear_probe_key_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #4 clk = ~clk;

	// shadow copy of the table
	bit [1:0]    tbl_state     [SLOTS];
	bit [63:0]   tbl_outer     [SLOTS];
	bit [63:0]   tbl_inner     [SLOTS];
	bit          tbl_has_inner [SLOTS];
	int unsigned tbl_count = 0;

	lpkt_rsp_t   expected_rsp_q[$];
	lpkt_req_t   key_pool[$];
	int unsigned mismatch_count = 0;
	int unsigned req_count      = 0;
	int unsigned checked_count  = 0;
	int unsigned code_seen[8];
	int unsigned eot_seen       = 0;
	int unsigned idle_cycles    = 0;
	int unsigned burst_left     = 0;
	int unsigned rx_cycle       = 0;
	rx_mode_e    rx_mode        = RX_FREE;

	function automatic bit chain_find(input int unsigned home, input bit [63:0] okey,
			input bit hi, input bit [63:0] ikey, output int unsigned at);
		int unsigned s;
		int unsigned n;
		s  = home;
		at = 0;
		for (n = 0; n < SLOTS; n++) begin
			if (tbl_state[s] == SLOT_EMPTY)
				return 1'b0;
			if (tbl_state[s] == SLOT_FILLED && tbl_outer[s] == okey && tbl_has_inner[s] == hi
					&& (!hi || tbl_inner[s] == ikey)) begin
				at = s;
				return 1'b1;
			end
			s = (s + 1) & SLOT_MASK;
		end
		return 1'b0;
	endfunction

	function automatic lpkt_rsp_t key_table_predict(input lpkt_req_t r);
		lpkt_rsp_t   res;
		bit          hi;
		bit [31:0]   in_cls;
		bit [31:0]   in_sel;
		bit [63:0]   okey;
		bit [63:0]   ikey;
		int unsigned home;
		int unsigned at;
		int unsigned s;
		int unsigned n;
		res             = '0;
		res.result_code = RC_NONE;
		hi     = r.has_inner;
		in_cls = hi ? r.inner_class_id : 32'd0;
		in_sel = hi ? r.inner_selector_id : 32'd0;
		okey   = {r.outer_class_id, r.outer_selector_id};
		ikey   = {in_cls, in_sel};
		home   = (r.outer_class_id ^ r.outer_selector_id ^ in_cls ^ in_sel) & SLOT_MASK;
		case (r.operation)
			OP_INSERT: begin
				if (chain_find(home, okey, hi, ikey, at)) begin
					res.result_code = RC_PRESENT;
					res.slot_index  = 12'(at);
				end else if (tbl_count * 2 >= SLOTS) begin
					res.result_code = RC_FULL;
				end else begin
					s = home;
					for (n = 0; n < SLOTS; n++) begin
						if (tbl_state[s] != SLOT_FILLED)
							break;
						s = (s + 1) & SLOT_MASK;
					end
					tbl_state[s]     = SLOT_FILLED;
					tbl_outer[s]     = okey;
					tbl_inner[s]     = ikey;
					tbl_has_inner[s] = hi;
					tbl_count++;
					res.result_code  = RC_INSERTED;
					res.slot_index   = 12'(s);
				end
			end
			OP_LOOKUP, OP_REMOVE: begin
				if (tbl_count != 0 && chain_find(home, okey, hi, ikey, at)) begin
					res.slot_index = 12'(at);
					if (r.operation == OP_REMOVE) begin
						tbl_state[at]   = SLOT_DELETED;
						tbl_count--;
						res.result_code = RC_REMOVED;
					end else begin
						res.result_code = RC_HIT;
					end
				end else begin
					res.result_code = RC_MISS;
				end
			end
			OP_TAKE: begin
				res.scan_exhausted = 1'b1;
				for (s = 0; s < SLOTS; s++) begin
					if (tbl_state[s] == SLOT_FILLED && !tbl_has_inner[s]) begin
						tbl_state[s]          = SLOT_DELETED;
						tbl_count--;
						res.result_code       = RC_REMOVED;
						res.slot_index        = 12'(s);
						res.found_class_id    = tbl_outer[s][63:32];
						res.found_selector_id = tbl_outer[s][31:0];
						res.scan_exhausted    = 1'b0;
						break;
					end
				end
			end
			OP_CLEAR: begin
				for (s = 0; s < SLOTS; s++)
					tbl_state[s] = SLOT_EMPTY;
				tbl_count = 0;
			end
			default: ;
		endcase
		res.entry_count = 12'(tbl_count);
		return res;
	endfunction

	task automatic report_mismatch(input int unsigned idx, input string what,
			input logic [31:0] got, input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: result %0d %s: got %h, expected %h", $time, idx, what, got, want);
	endtask

	// request and result monitor, with the no-progress watchdog
	always @(posedge clk) begin : monitor
		lpkt_rsp_t want;
		bit        moved;
		moved = 1'b0;
		if (arst_n && req_valid && req_stall === 1'b0) begin
			expected_rsp_q.push_back(key_table_predict(req_data));
			req_count++;
			moved = 1'b1;
		end
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			moved = 1'b1;
			if (expected_rsp_q.size() == 0) begin
				report_mismatch(checked_count, "beat with nothing pending", rsp_data[31:0], '0);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp_data.result_code !== want.result_code)
					report_mismatch(checked_count, "result_code", 32'(rsp_data.result_code),
						32'(want.result_code));
				if (rsp_data.slot_index !== want.slot_index)
					report_mismatch(checked_count, "slot_index", 32'(rsp_data.slot_index),
						32'(want.slot_index));
				if (rsp_data.found_class_id !== want.found_class_id)
					report_mismatch(checked_count, "found_class_id", rsp_data.found_class_id,
						want.found_class_id);
				if (rsp_data.found_selector_id !== want.found_selector_id)
					report_mismatch(checked_count, "found_selector_id",
						rsp_data.found_selector_id, want.found_selector_id);
				if (rsp_data.entry_count !== want.entry_count)
					report_mismatch(checked_count, "entry_count", 32'(rsp_data.entry_count),
						32'(want.entry_count));
				if (rsp_data.scan_exhausted !== want.scan_exhausted)
					report_mismatch(checked_count, "scan_exhausted",
						32'(rsp_data.scan_exhausted), 32'(want.scan_exhausted));
				code_seen[want.result_code]++;
				if (want.scan_exhausted)
					eot_seen++;
			end
			checked_count++;
		end
		if (moved)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, idle_cycles);
			$display("[linear_probe_key_table] ERROR");
			$finish;
		end
	end

	// result-side backpressure in one of four randomly picked patterns
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = rx_mode_e'($urandom_range(RX_FREE, RX_PERIODIC));
		case (rx_mode)
			RX_FREE:     rsp_stall <= 1'b0;
			RX_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: rsp_stall <= (rx_cycle % 16 < 5);
			default:     rsp_stall <= 1'b0;
		endcase
	end

	task automatic send_item(input logic [2:0] op, input lpkt_req_t k);
		k.operation = op;
		req_valid <= 1'b1;
		req_data  <= k;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 6);
		end
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_rsp_q.size() != 0);
	endtask

	function automatic bit coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic lpkt_req_t rand_key(input bit hi);
		lpkt_req_t k;
		k.operation         = OP_INSERT;
		k.outer_class_id    = $urandom();
		k.outer_selector_id = $urandom();
		k.has_inner         = hi;
		k.inner_class_id    = $urandom();
		k.inner_selector_id = $urandom();
		return k;
	endfunction

	// random key whose home slot is forced
	function automatic lpkt_req_t clustered_key(input bit hi, input logic [11:0] home);
		lpkt_req_t   k;
		logic [31:0] mix;
		k   = rand_key(hi);
		mix = k.outer_class_id ^ {20'd0, home};
		if (hi)
			mix = mix ^ k.inner_class_id ^ k.inner_selector_id;
		k.outer_selector_id[11:0] = mix[11:0];
		return k;
	endfunction

	function automatic void remember_key(input lpkt_req_t k);
		if (key_pool.size() < POOL_DEPTH)
			key_pool.push_back(k);
		else
			key_pool[$urandom_range(0, POOL_DEPTH - 1)] = k;
	endfunction

	task automatic test_empty_table();
		lpkt_req_t k;
		k = rand_key(1'b1);
		send_item(OP_LOOKUP, k);
		send_item(OP_REMOVE, k);
		send_item(OP_TAKE, k);
		send_item(3'(OP_CLEAR + 1), k);
		send_item('1, rand_key(1'b0));
		send_item(OP_CLEAR, k);
		wait_for_results();
	endtask

	task automatic test_basic_keys();
		lpkt_req_t a;
		lpkt_req_t b;
		lpkt_req_t ones;
		lpkt_req_t zeros;
		a    = rand_key(1'b0);
		b    = rand_key(1'b1);
		ones = '1;
		zeros = '0;
		send_item(OP_INSERT, a);
		// inner fields are ignored without has_inner
		a.inner_class_id = ~a.inner_class_id;
		send_item(OP_INSERT, a);
		send_item(OP_INSERT, b);
		b.has_inner = 1'b0;
		send_item(OP_LOOKUP, b);
		b.has_inner = 1'b1;
		send_item(OP_LOOKUP, b);
		send_item(OP_INSERT, ones);
		send_item(OP_INSERT, zeros);
		send_item(OP_REMOVE, a);
		send_item(OP_LOOKUP, a);
		send_item(OP_TAKE, a);
		send_item(OP_TAKE, a);
		wait_for_results();
	endtask

	task automatic test_wrap_and_tombstones();
		lpkt_req_t k[4];
		send_item(OP_CLEAR, rand_key(1'b0));
		for (int i = 0; i < 4; i++) begin
			k[i] = clustered_key(i[0], 12'(SLOT_MASK));
			send_item(OP_INSERT, k[i]);
		end
		// chain wraps past the last slot; a tombstone must not end the search
		send_item(OP_REMOVE, k[1]);
		send_item(OP_LOOKUP, k[2]);
		send_item(OP_INSERT, k[3]);
		send_item(OP_INSERT, k[1]);
		send_item(OP_TAKE, k[0]);
		wait_for_results();
	endtask

	task automatic test_fill_to_capacity();
		lpkt_req_t k;
		lpkt_req_t last;
		send_item(OP_CLEAR, rand_key(1'b0));
		for (int i = 0; i < SLOTS / 2; i++) begin
			last = rand_key(coin());
			send_item(OP_INSERT, last);
		end
		for (int i = 0; i < 3; i++)
			send_item(OP_INSERT, rand_key(coin()));
		// duplicate check comes before the full check
		send_item(OP_INSERT, last);
		send_item(OP_LOOKUP, last);
		send_item(OP_REMOVE, last);
		k = rand_key(1'b0);
		send_item(OP_INSERT, k);
		send_item(OP_INSERT, rand_key(1'b1));
		send_item(OP_TAKE, k);
		send_item(OP_CLEAR, k);
		wait_for_results();
	endtask

	task automatic test_random_mix();
		lpkt_req_t   k;
		int unsigned pick;
		logic [2:0]  op;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			// picks that reuse a pooled key need one first
			if (key_pool.size() == 0 && pick >= 25 && pick < 80)
				pick = 0;
			if (key_pool.size() != 0)
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			if (pick < 25) begin
				if ($urandom_range(0, 9) < 4)
					k = clustered_key(coin(), 12'($urandom_range(SLOTS - 6, SLOTS + 3)));
				else
					k = rand_key(coin());
				remember_key(k);
				send_item(OP_INSERT, k);
			end else if (pick < 35) begin
				if (!k.has_inner) begin
					k.inner_class_id    = $urandom();
					k.inner_selector_id = $urandom();
				end
				send_item(OP_INSERT, k);
			end else if (pick < 55) begin
				send_item(OP_LOOKUP, k);
			end else if (pick < 70) begin
				send_item(OP_REMOVE, k);
			end else if (pick < 75) begin
				send_item(OP_LOOKUP, rand_key(coin()));
			end else if (pick < 80) begin
				// same ids, other key kind
				k.has_inner = ~k.has_inner;
				case ($urandom_range(0, 2))
					0:       op = OP_INSERT;
					1:       op = OP_LOOKUP;
					default: op = OP_REMOVE;
				endcase
				send_item(op, k);
			end else if (pick < 86) begin
				send_item(OP_TAKE, rand_key(coin()));
			end else if (pick < 88) begin
				send_item(OP_CLEAR, rand_key(coin()));
			end else if (pick < 91) begin
				op = 3'($urandom_range(int'(OP_CLEAR) + 1, (1 << $bits(op)) - 1));
				send_item(op, rand_key(coin()));
			end else begin
				send_item(OP_REMOVE, rand_key(coin()));
			end
			if (i == RANDOM_ITEMS / 2)
				wait_for_results();
		end
		wait_for_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_basic_keys();
		test_wrap_and_tombstones();
		test_fill_to_capacity();
		test_random_mix();
		// a take-next or clear may still be walking the table
		req_valid <= 1'b0;
		repeat (SLOTS + 64) @(posedge clk);
		if (expected_rsp_q.size() != 0)
			report_mismatch(checked_count, "results never delivered",
				32'(expected_rsp_q.size()), '0);
		$display("covered %0d requests and %0d results: %0d inserted, %0d duplicate, %0d full,",
			req_count, checked_count, code_seen[RC_INSERTED], code_seen[RC_PRESENT],
			code_seen[RC_FULL]);
		$display("  %0d hit, %0d miss, %0d removed, %0d none (%0d end of table)",
			code_seen[RC_HIT], code_seen[RC_MISS], code_seen[RC_REMOVED],
			code_seen[RC_NONE], eot_seen);
		if (mismatch_count == 0)
			$display("[linear_probe_key_table] OK");
		else
			$display("[linear_probe_key_table] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
